@@ hw/rtl/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect package
// Effect mode codes, fixed-point constants and the x-ray response table.
// ----------------------------------------------------------------------------
package pce_pkg;

    // Effect selected by the mode register
    typedef enum logic [1:0] {
        MODE_GRAY  = 2'd0,
        MODE_NEG   = 2'd1,
        MODE_XRAY  = 2'd2,
        MODE_SEPIA = 2'd3
    } mode_t;

    // One RGB pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Luma weights in thousandths
    localparam int unsigned LUMA_W_R = 299;
    localparam int unsigned LUMA_W_G = 587;
    localparam int unsigned LUMA_W_B = 114;

    // floor(s / 1000) = (s * LUMA_RECIP) >> LUMA_SHIFT for s <= 255000
    localparam int unsigned LUMA_SHIFT = 28;
    localparam int unsigned LUMA_RECIP = 268436;

    // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT for x < 16384
    localparam int unsigned DIV10_SHIFT = 15;
    localparam int unsigned DIV10_RECIP = 3277;

    // Sepia gains and offsets
    localparam int unsigned SEPIA_UP_GAIN   = 11;
    localparam int unsigned SEPIA_DOWN_GAIN = 9;
    localparam int unsigned SEPIA_OFFSET    = 10;
    localparam int unsigned SEPIA_BIAS      = 100;
    localparam int unsigned CHAN_MAX        = 255;

    // floor(sqrt(l^3)); saturates to 255 from luma 41 up
    function automatic logic [7:0] xray_lut(input logic [7:0] l);
        logic [7:0] v;
        case (l)
            8'd0:  v = 8'd0;
            8'd1:  v = 8'd1;
            8'd2:  v = 8'd2;
            8'd3:  v = 8'd5;
            8'd4:  v = 8'd8;
            8'd5:  v = 8'd11;
            8'd6:  v = 8'd14;
            8'd7:  v = 8'd18;
            8'd8:  v = 8'd22;
            8'd9:  v = 8'd27;
            8'd10: v = 8'd31;
            8'd11: v = 8'd36;
            8'd12: v = 8'd41;
            8'd13: v = 8'd46;
            8'd14: v = 8'd52;
            8'd15: v = 8'd58;
            8'd16: v = 8'd64;
            8'd17: v = 8'd70;
            8'd18: v = 8'd76;
            8'd19: v = 8'd82;
            8'd20: v = 8'd89;
            8'd21: v = 8'd96;
            8'd22: v = 8'd103;
            8'd23: v = 8'd110;
            8'd24: v = 8'd117;
            8'd25: v = 8'd125;
            8'd26: v = 8'd132;
            8'd27: v = 8'd140;
            8'd28: v = 8'd148;
            8'd29: v = 8'd156;
            8'd30: v = 8'd164;
            8'd31: v = 8'd172;
            8'd32: v = 8'd181;
            8'd33: v = 8'd189;
            8'd34: v = 8'd198;
            8'd35: v = 8'd207;
            8'd36: v = 8'd216;
            8'd37: v = 8'd225;
            8'd38: v = 8'd234;
            8'd39: v = 8'd243;
            8'd40: v = 8'd252;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/pixel_color_effect_unit.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect unit
// Grayscale, negative, x-ray or sepia effect on an 8-bit RGB pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while m_tready does not stall the output; the four-stage
//   pipeline with the luma reciprocal multiply in stage 3 sets the clock, not the rate.
// Reset: aresetn clears all stage valid bits and sets the mode to grayscale.
// Back-pressure stalls only the stages that are full; empty stages keep filling.
module pixel_color_effect_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: effect mode
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    // Input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic        s_tlast,   // final_pixel
    // Output pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic        m_tlast    // final_out
);

    // ------------------------------------------------------------------
    // Mode register
    // ------------------------------------------------------------------
    pce_pkg::mode_t mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pce_pkg::MODE_GRAY;
        end else if (cfg_wr_en) begin
            mode_reg <= pce_pkg::mode_t'(cfg_wr_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || m_tready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= s_tvalid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: weighted channel products and sepia gains
    // ------------------------------------------------------------------
    pce_pkg::pixel_t in_pix;
    assign in_pix = pce_pkg::pixel_t'(s_tdata);

    pce_pkg::pixel_t s1_pix_reg;
    pce_pkg::mode_t  s1_mode_reg;
    logic            s1_last_reg;
    logic [16:0]     s1_prod_r_reg;
    logic [17:0]     s1_prod_g_reg;
    logic [14:0]     s1_prod_b_reg;
    logic [11:0]     s1_up_r_reg, s1_up_g_reg, s1_down_b_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_pix_reg    <= in_pix;
            s1_mode_reg   <= mode_reg;
            s1_last_reg   <= s_tlast;
            s1_prod_r_reg <= 17'(in_pix.red)   * 17'(pce_pkg::LUMA_W_R);
            s1_prod_g_reg <= 18'(in_pix.green) * 18'(pce_pkg::LUMA_W_G);
            s1_prod_b_reg <= 15'(in_pix.blue)  * 15'(pce_pkg::LUMA_W_B);
            s1_up_r_reg   <= 12'(in_pix.red)   * 12'(pce_pkg::SEPIA_UP_GAIN);
            s1_up_g_reg   <= 12'(in_pix.green) * 12'(pce_pkg::SEPIA_UP_GAIN);
            s1_down_b_reg <= 12'(in_pix.blue)  * 12'(pce_pkg::SEPIA_DOWN_GAIN);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: luma sum, sepia divide by ten
    // ------------------------------------------------------------------
    logic [23:0] up_r_prod, up_g_prod, down_b_prod;
    logic [11:0] down_b_biased;
    logic        down_b_zero;

    assign down_b_zero   = s1_down_b_reg < 12'(pce_pkg::SEPIA_BIAS);
    assign down_b_biased = s1_down_b_reg - 12'(pce_pkg::SEPIA_BIAS);
    assign up_r_prod     = 24'(s1_up_r_reg)   * 24'(pce_pkg::DIV10_RECIP);
    assign up_g_prod     = 24'(s1_up_g_reg)   * 24'(pce_pkg::DIV10_RECIP);
    assign down_b_prod   = 24'(down_b_biased) * 24'(pce_pkg::DIV10_RECIP);

    pce_pkg::pixel_t s2_pix_reg;
    pce_pkg::mode_t  s2_mode_reg;
    logic            s2_last_reg;
    logic [17:0]     s2_sum_reg;
    logic [8:0]      s2_q_r_reg, s2_q_g_reg;
    logic [7:0]      s2_sepia_b_reg;

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_pix_reg     <= s1_pix_reg;
            s2_mode_reg    <= s1_mode_reg;
            s2_last_reg    <= s1_last_reg;
            s2_sum_reg     <= 18'(s1_prod_r_reg) + s1_prod_g_reg + 18'(s1_prod_b_reg);
            s2_q_r_reg     <= up_r_prod[pce_pkg::DIV10_SHIFT +: 9];
            s2_q_g_reg     <= up_g_prod[pce_pkg::DIV10_SHIFT +: 9];
            s2_sepia_b_reg <= down_b_zero ? 8'd0 : down_b_prod[pce_pkg::DIV10_SHIFT +: 8];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: luma by reciprocal multiply, sepia offset and clamp
    // ------------------------------------------------------------------
    logic [36:0] luma_prod;
    logic [9:0]  up_r_sum, up_g_sum;

    assign luma_prod = 37'(s2_sum_reg) * 37'(pce_pkg::LUMA_RECIP);
    assign up_r_sum  = 10'(s2_q_r_reg) + 10'(pce_pkg::SEPIA_OFFSET);
    assign up_g_sum  = 10'(s2_q_g_reg) + 10'(pce_pkg::SEPIA_OFFSET);

    pce_pkg::pixel_t s3_pix_reg;
    pce_pkg::pixel_t s3_sepia_reg;
    pce_pkg::mode_t  s3_mode_reg;
    logic            s3_last_reg;
    logic [7:0]      s3_luma_reg;

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_pix_reg         <= s2_pix_reg;
            s3_mode_reg        <= s2_mode_reg;
            s3_last_reg        <= s2_last_reg;
            s3_luma_reg        <= luma_prod[pce_pkg::LUMA_SHIFT +: 8];
            s3_sepia_reg.red   <= (up_r_sum > 10'(pce_pkg::CHAN_MAX)) ? 8'hFF : up_r_sum[7:0];
            s3_sepia_reg.green <= (up_g_sum > 10'(pce_pkg::CHAN_MAX)) ? 8'hFF : up_g_sum[7:0];
            s3_sepia_reg.blue  <= s2_sepia_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: x-ray lookup and effect select into the output register
    // ------------------------------------------------------------------
    pce_pkg::pixel_t effect_pix;
    logic [7:0]      xray_val;

    assign xray_val = pce_pkg::xray_lut(s3_luma_reg);

    always_comb begin
        case (s3_mode_reg)
            pce_pkg::MODE_GRAY:  effect_pix = '{blue: s3_luma_reg, green: s3_luma_reg,
                                                red: s3_luma_reg};
            pce_pkg::MODE_NEG:   effect_pix = pce_pkg::pixel_t'(~s3_pix_reg);
            pce_pkg::MODE_XRAY:  effect_pix = '{blue: xray_val, green: xray_val,
                                                red: xray_val};
            default:             effect_pix = s3_sepia_reg;
        endcase
    end

    pce_pkg::pixel_t s4_pix_reg;
    pce_pkg::mode_t  s4_mode_reg;
    logic            s4_last_reg;

    always_ff @(posedge aclk) begin
        if (s4_ready) begin
            s4_pix_reg  <= effect_pix;
            s4_mode_reg <= s3_mode_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = s4_valid_reg;
    assign m_tdata  = s4_pix_reg;
    assign m_tlast  = s4_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input stalls only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg &&
                       s4_valid_reg && !m_tready))
        else $error("input stalled with a free pipeline stage");

    // An accepted beat lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted beat lost at stage 1");

    // Grayscale and x-ray give equal channels
    a_mono_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (s4_mode_reg == pce_pkg::MODE_GRAY ||
                      s4_mode_reg == pce_pkg::MODE_XRAY))
        |-> (s4_pix_reg.red == s4_pix_reg.green && s4_pix_reg.green == s4_pix_reg.blue))
        else $error("monochrome effect with unequal channels");

    // Sepia red and green never fall below the offset
    a_sepia_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && s4_mode_reg == pce_pkg::MODE_SEPIA)
        |-> (s4_pix_reg.red >= 8'(pce_pkg::SEPIA_OFFSET) &&
             s4_pix_reg.green >= 8'(pce_pkg::SEPIA_OFFSET)))
        else $error("sepia channel below offset");

endmodule

@@ tb/pce_checker.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect checker
// Watches the input and output pixel streams and the mode register writes of
// the effect unit. Predicts each output beat from its input beat and compares
// the two field by field, in order.
// ----------------------------------------------------------------------------
module pce_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [23:0]        s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic               s_tlast,   // final_pixel
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [23:0]        m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    input  logic               m_tlast,   // final_out
    output int unsigned        mismatch_count,
    output int unsigned        pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pce_pkg::pixel_t px;
        logic            last;
    } out_beat_t;

    pce_pkg::mode_t effect_mode;
    out_beat_t      predicted_pixels[$];

    // Sepia boost for red and green: 1.1 gain plus offset, clipped
    function automatic logic [7:0] sepia_boost(input logic [7:0] c);
        int unsigned v;
        v = (pce_pkg::SEPIA_UP_GAIN * int'(c)) / 10 + pce_pkg::SEPIA_OFFSET;
        return (v > pce_pkg::CHAN_MAX) ? 8'd255 : v[7:0];
    endfunction

    // Expected output pixel for one input pixel under the given effect
    function automatic pce_pkg::pixel_t apply_effect(input pce_pkg::mode_t mode,
                                                     input pce_pkg::pixel_t px);
        int unsigned     luma;
        int unsigned     root;
        int unsigned     scaled;
        pce_pkg::pixel_t res;
        luma = (299 * int'(px.red) + 587 * int'(px.green) + 114 * int'(px.blue)) / 1000;
        case (mode)
            pce_pkg::MODE_GRAY: begin
                res = '{blue: luma[7:0], green: luma[7:0], red: luma[7:0]};
            end
            pce_pkg::MODE_NEG: begin
                res = '{blue: ~px.blue, green: ~px.green, red: ~px.red};
            end
            pce_pkg::MODE_XRAY: begin
                // floor(sqrt(luma^3)), stopping at full scale
                root = 0;
                while (root < pce_pkg::CHAN_MAX &&
                       (root + 1) * (root + 1) <= luma * luma * luma)
                    root++;
                res = '{blue: root[7:0], green: root[7:0], red: root[7:0]};
            end
            default: begin
                // Blue drops by 0.9 gain minus offset, floored at zero
                scaled = pce_pkg::SEPIA_DOWN_GAIN * int'(px.blue);
                scaled = (scaled < pce_pkg::SEPIA_BIAS) ? 0 :
                         (scaled - pce_pkg::SEPIA_BIAS) / 10;
                res = '{blue: scaled[7:0], green: sepia_boost(px.green),
                        red: sepia_boost(px.red)};
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        out_beat_t       want;
        pce_pkg::pixel_t got;
        if (!aresetn) begin
            effect_mode = pce_pkg::MODE_GRAY;
            predicted_pixels.delete();
            mismatch_count = 0;
        end else begin
            // Compare an output beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = pce_pkg::pixel_t'(m_tdata);
                if (predicted_pixels.size() == 0) begin
                    $error("unexpected output beat: data %h last %b", m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = predicted_pixels.pop_front();
                    if (got.red !== want.px.red) begin
                        $error("red_out: expected %0d, got %0d", want.px.red, got.red);
                        mismatch_count++;
                    end
                    if (got.green !== want.px.green) begin
                        $error("green_out: expected %0d, got %0d", want.px.green, got.green);
                        mismatch_count++;
                    end
                    if (got.blue !== want.px.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.px.blue, got.blue);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("final_out: expected %0d, got %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            // Predict every accepted input beat under the current mode
            if (s_tvalid && s_tready) begin
                predicted_pixels.push_back(
                    '{px: apply_effect(effect_mode, pce_pkg::pixel_t'(s_tdata)),
                      last: s_tlast});
            end
            // Track mode register writes
            if (cfg_wr_en)
                effect_mode = pce_pkg::mode_t'(cfg_wr_data);
        end
        pending_pixels = predicted_pixels.size();
    end

endmodule

@@ tb/tb_pixel_color_effect_unit.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect unit testbench
// Drives directed and random pixels through every effect mode with random
// idle cycles on both streams and one long output stall, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_pixel_color_effect_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red_in[7:0], green_in[15:8], blue_in[23:16]
    logic        s_tlast;   // final_pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic        m_tlast;   // final_out

    int unsigned mismatch_count;
    int unsigned pending_pixels;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_requests = 0;

    pixel_color_effect_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    pce_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_pixels (pending_pixels)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // Output side: random ready, plus long stalls on request
    initial begin
        int unsigned stalls_done;
        stalls_done = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_requests != stalls_done) begin
                stalls_done++;
                for (int n = 0; n < 80; n++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one beat after random idle cycles; return at the negedge after acceptance
    task automatic send_pixel(input pce_pkg::pixel_t px, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drain the pipeline, then write the mode register
    task automatic set_effect(input pce_pkg::mode_t mode);
        s_tvalid <= 1'b0;
        while (pending_pixels != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Channel value biased toward the extremes
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pce_pkg::pixel_t rand_pixel();
        return '{blue: rand_channel(), green: rand_channel(), red: rand_channel()};
    endfunction

    initial begin
        pce_pkg::pixel_t directed[6];
        int unsigned     idle_send[3];
        int unsigned     idle_recv[3];
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 2'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        // Black, white, x-ray knee at luma 40/41, sepia clip and blue floor
        directed[0] = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
        directed[1] = '{blue: 8'd255, green: 8'd255, red: 8'd255};
        directed[2] = '{blue: 8'd40,  green: 8'd40,  red: 8'd40};
        directed[3] = '{blue: 8'd41,  green: 8'd41,  red: 8'd41};
        directed[4] = '{blue: 8'd11,  green: 8'd222, red: 8'd223};
        directed[5] = '{blue: 8'd12,  green: 8'd85,  red: 8'd170};
        idle_send = '{29, 72, 0};
        idle_recv = '{72, 29, 0};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pixels in every mode
        send_idle_pct = idle_send[0];
        recv_idle_pct = idle_recv[0];
        for (int m = 0; m < 4; m++) begin
            set_effect(pce_pkg::mode_t'(m));
            for (int k = 0; k < 6; k++)
                send_pixel(directed[k], k[0]);
        end

        // Random pixels, one idle profile per phase, all modes in each
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = idle_send[p];
            recv_idle_pct = idle_recv[p];
            if (p == 2) begin
                // Back up the pipeline behind a long output stall
                set_effect(pce_pkg::MODE_SEPIA);
                stall_requests++;
                repeat (30) send_pixel(rand_pixel(), 1'($urandom_range(0, 1)));
            end
            for (int m = 0; m < 4; m++) begin
                set_effect(pce_pkg::mode_t'((m + 3 * p) % 4));
                repeat (38) send_pixel(rand_pixel(), $urandom_range(0, 7) == 0);
            end
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (pending_pixels != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
